// ===== rtl/e3hp_pkg.sv =====
// ----------------------------------------------------------------------------
// e3hp_pkg
// Types, codes and routing functions shared by the E-AC-3 header parser.
// ----------------------------------------------------------------------------
package e3hp_pkg;

    localparam logic [15:0] SYNC_WORD = 16'h0B77;
    localparam logic [4:0]  BSID_MIN  = 5'd11;
    localparam logic [4:0]  BSID_MAX  = 5'd16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADSYNC = 2'd1,
        ST_BADBSID = 2'd2,
        ST_RESTART = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        P_IDLE, P_DONE, P_BADSYNC, P_BADBSID,
        P_SYNC, P_STRMTYP, P_SUBID, P_FRMSIZ, P_FSCOD, P_FSCOD2, P_NUMBLKS,
        P_ACMOD, P_LFEON, P_BSID, P_DIALNORM, P_COMPRE, P_COMPR, P_DIALNORM2,
        P_COMPR2E, P_COMPR2, P_CHANMAPE, P_CHANMAP, P_MIXMDATE, P_DMIX, P_CMIX,
        P_SURMIX, P_LFEMIXE, P_LFEMIXCOD, P_PGMSCLE, P_PGMSCL, P_PGMSCL2E,
        P_PGMSCL2, P_EXTPGMSCLE, P_EXTPGMSCL, P_MIXDEF, P_PREMIX, P_MIXDATA,
        P_MIXDEFLEN, P_MIXSKIP, P_PANE, P_PAN, P_PAN2E, P_PAN2, P_FRMMIXCFGE,
        P_BLKCFG0, P_BLKCFGE, P_BLKCFG, P_INFOMDATE, P_INFOA, P_DSUR, P_DSUREX,
        P_AUDPRODIE, P_AUDPRODI, P_AUDPRODI2E, P_AUDPRODI2, P_SRCFS,
        P_CONVSYNC, P_BLKID, P_FRMSIZECOD, P_ADDBSIE, P_ADDBSIL, P_ADDSKIP
    } t_phase;

    typedef struct packed {
        logic [1:0]  stream_type;
        logic [2:0]  substream_id;
        logic [10:0] frame_size_words;
        logic [1:0]  rate_code;
        logic [1:0]  reduced_rate_code;
        logic [1:0]  blocks_code;
        logic [2:0]  channel_mode;
        logic        lfe_present;
        logic [4:0]  stream_id;
        logic [4:0]  dialogue_level;
    } t_fields;

    typedef struct packed {
        t_phase     ph;
        logic [4:0] bits;
    } t_goto;

    // one queued input beat
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_qbeat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic t_goto f_go(t_phase ph, logic [4:0] bits);
        t_goto g;
        g.ph   = ph;
        g.bits = bits;
        return g;
    endfunction

    function automatic logic [2:0] f_blocks(logic [1:0] code);
        logic [2:0] r;
        unique case (code)
            2'd0: r = 3'd1;
            2'd1: r = 3'd2;
            2'd2: r = 3'd3;
            default: r = 3'd6;
        endcase
        return r;
    endfunction

    function automatic t_goto to_blkid(t_fields f);
        if (f.stream_type == 2'd2)
            return (f.blocks_code == 2'd3) ? f_go(P_FRMSIZECOD, 5'd6) : f_go(P_BLKID, 5'd1);
        return f_go(P_ADDBSIE, 5'd1);
    endfunction

    function automatic t_goto to_convsync(t_fields f);
        if (f.stream_type == 2'd0 && f.blocks_code != 2'd3) return f_go(P_CONVSYNC, 5'd1);
        return to_blkid(f);
    endfunction

    function automatic t_goto to_sourcefs(t_fields f);
        if (f.rate_code != 2'd3) return f_go(P_SRCFS, 5'd1);
        return to_convsync(f);
    endfunction

    function automatic t_goto to_audprodi2e(t_fields f);
        if (f.channel_mode == 3'd0) return f_go(P_AUDPRODI2E, 5'd1);
        return to_sourcefs(f);
    endfunction

    function automatic t_goto to_dsurex(t_fields f);
        if (f.channel_mode >= 3'd6) return f_go(P_DSUREX, 5'd2);
        return f_go(P_AUDPRODIE, 5'd1);
    endfunction

    function automatic t_goto to_dsur(t_fields f);
        if (f.channel_mode == 3'd2) return f_go(P_DSUR, 5'd4);
        return to_dsurex(f);
    endfunction

    function automatic t_goto to_blkloop(t_fields f, logic [2:0] idx);
        if (idx < f_blocks(f.blocks_code)) return f_go(P_BLKCFGE, 5'd1);
        return f_go(P_INFOMDATE, 5'd1);
    endfunction

    function automatic t_goto to_pan2(t_fields f);
        if (f.channel_mode == 3'd0) return f_go(P_PAN2E, 5'd1);
        return f_go(P_FRMMIXCFGE, 5'd1);
    endfunction

    function automatic t_goto to_pan(t_fields f);
        if (f.channel_mode < 3'd2) return f_go(P_PANE, 5'd1);
        return f_go(P_FRMMIXCFGE, 5'd1);
    endfunction

    function automatic t_goto to_pgm2(t_fields f);
        if (f.channel_mode == 3'd0) return f_go(P_PGMSCL2E, 5'd1);
        return f_go(P_EXTPGMSCLE, 5'd1);
    endfunction

    function automatic t_goto to_pgm(t_fields f);
        if (f.stream_type == 2'd0) return f_go(P_PGMSCLE, 5'd1);
        return f_go(P_INFOMDATE, 5'd1);
    endfunction

    function automatic t_goto to_lfemix(t_fields f);
        if (f.lfe_present) return f_go(P_LFEMIXE, 5'd1);
        return to_pgm(f);
    endfunction

    function automatic t_goto to_surmix(t_fields f);
        if (f.channel_mode[2]) return f_go(P_SURMIX, 5'd6);
        return to_lfemix(f);
    endfunction

    function automatic t_goto to_cmix(t_fields f);
        if (f.channel_mode[0] && f.channel_mode > 3'd2) return f_go(P_CMIX, 5'd6);
        return to_surmix(f);
    endfunction

    function automatic t_goto to_dmix(t_fields f);
        if (f.channel_mode > 3'd2) return f_go(P_DMIX, 5'd2);
        return to_cmix(f);
    endfunction

    function automatic t_goto to_chanmape(t_fields f);
        if (f.stream_type == 2'd1) return f_go(P_CHANMAPE, 5'd1);
        return f_go(P_MIXMDATE, 5'd1);
    endfunction

    function automatic t_goto to_dual(t_fields f);
        if (f.channel_mode == 3'd0) return f_go(P_DIALNORM2, 5'd5);
        return to_chanmape(f);
    endfunction

endpackage

// ===== rtl/eac3_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// eac3_header_field_parser
// E-AC-3 bit stream info parser: syncword check, full header walk, one result.
// ----------------------------------------------------------------------------
// Flow: each header byte is loaded, then walked one header bit per cycle while
//   the output is not stalled; the next beat waits until the walker is done;
//   a two-beat queue decouples the input. An early restart result registers
//   at the same edge that pops the new frame's first byte.
// Reset: synchronous, active low; queue empties, parser idles, no result held.
// ----------------------------------------------------------------------------
module eac3_header_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_stream_type,
    output logic [2:0]  o_substream_id,
    output logic [10:0] o_frame_size_words,
    output logic [1:0]  o_rate_code,
    output logic [1:0]  o_reduced_rate_code,
    output logic [1:0]  o_blocks_code,
    output logic [2:0]  o_channel_mode,
    output logic        o_lfe_present,
    output logic [4:0]  o_stream_id,
    output logic [4:0]  o_dialogue_level,
    output logic [9:0]  o_header_bytes
);
    e3hp_pkg::t_qbeat  q_head;
    e3hp_pkg::t_qstat  q_stat;
    e3hp_pkg::t_fields res_f;
    logic              q_pop;

    // front: hold incoming beats until the walker is free
    e3hp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .i_pop        (q_pop),
        .o_head       (q_head),
        .o_stat       (q_stat)
    );

    // back: walk header bits, advance one bit per cycle unless the output stalls, register the result
    e3hp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_head_valid  (!q_stat.empty),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_fields      (res_f),
        .o_header_bytes(o_header_bytes)
    );

    assign o_stream_type       = res_f.stream_type;
    assign o_substream_id      = res_f.substream_id;
    assign o_frame_size_words  = res_f.frame_size_words;
    assign o_rate_code         = res_f.rate_code;
    assign o_reduced_rate_code = res_f.reduced_rate_code;
    assign o_blocks_code       = res_f.blocks_code;
    assign o_channel_mode      = res_f.channel_mode;
    assign o_lfe_present       = res_f.lfe_present;
    assign o_stream_id         = res_f.stream_id;
    assign o_dialogue_level    = res_f.dialogue_level;

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full)) else $error("queue both empty and full");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty) else $error("pop from empty queue");

    a_bytes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_header_bytes != 10'd0) else $error("result with no bytes");

    a_badsync_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == e3hp_pkg::ST_BADSYNC) |-> o_header_bytes == 10'd2)
        else $error("bad syncword not reported after two bytes");
endmodule

// ===== rtl/e3hp_front.sv =====
// ----------------------------------------------------------------------------
// e3hp_front
// Two-entry input queue; takes byte beats and hands them to the bit parser.
// ----------------------------------------------------------------------------
module e3hp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_frame_start,
    input  logic            i_pop,
    output e3hp_pkg::t_qbeat o_head,
    output e3hp_pkg::t_qstat o_stat
);
    e3hp_pkg::t_qbeat r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_pop && (r_cnt != 2'd0);
    assign o_head      = r_mem[r_rd];
    // empty, then full
    assign o_stat      = {(r_cnt == 2'd0), (r_cnt == 2'd2)};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr].data  <= i_data_byte;
            r_mem[r_wr].start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/e3hp_back.sv =====
// ----------------------------------------------------------------------------
// e3hp_back
// Bit-serial header walker: one header bit per cycle unless the output stalls, result register.
// ----------------------------------------------------------------------------
module e3hp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  e3hp_pkg::t_qbeat i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output e3hp_pkg::t_fields o_fields,
    output logic [9:0]       o_header_bytes
);
    e3hp_pkg::t_phase  r_phase, n_phase;
    logic [4:0]        r_left, n_left;
    logic [15:0]       r_shift, n_shift;
    logic [9:0]        r_skip, n_skip;
    logic [2:0]        r_blk, n_blk;
    e3hp_pkg::t_fields r_f, n_f;
    logic [9:0]        r_count, n_count;
    logic [7:0]        r_byte, n_byte;
    logic [2:0]        r_bitn, n_bitn;
    logic              r_busy, n_busy;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    e3hp_pkg::t_fields r_out_f, n_out_f;
    logic [9:0]        r_out_bytes, n_out_bytes;
    logic              out_free;

    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_pop          = !r_busy && i_head_valid && out_free;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_fields       = r_out_f;
    assign o_header_bytes = r_out_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= e3hp_pkg::P_IDLE;
            r_left      <= '0;
            r_shift     <= '0;
            r_skip      <= '0;
            r_blk       <= '0;
            r_f         <= '0;
            r_count     <= '0;
            r_bitn      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_shift     <= n_shift;
            r_skip      <= n_skip;
            r_blk       <= n_blk;
            r_f         <= n_f;
            r_count     <= n_count;
            r_bitn      <= n_bitn;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_out_status <= n_out_status;
        r_out_f      <= n_out_f;
        r_out_bytes  <= n_out_bytes;
    end

    always_comb begin
        e3hp_pkg::t_goto g;
        logic            done;
        logic [15:0]     v;
        logic            fin;
        g            = e3hp_pkg::f_go(e3hp_pkg::P_IDLE, 5'd0);
        done         = 1'b0;
        v            = '0;
        fin          = 1'b0;
        n_phase      = r_phase;
        n_left       = r_left;
        n_shift      = r_shift;
        n_skip       = r_skip;
        n_blk        = r_blk;
        n_f          = r_f;
        n_count      = r_count;
        n_byte       = r_byte;
        n_bitn       = r_bitn;
        n_busy       = r_busy;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_f      = r_out_f;
        n_out_bytes  = r_out_bytes;

        if (o_pop) begin
            n_byte = i_head.data;
            n_bitn = 3'd0;
            if (i_head.start) begin
                // early restart: report what the old frame gave so far
                if (r_phase != e3hp_pkg::P_IDLE) begin
                    n_out_valid  = 1'b1;
                    n_out_status = e3hp_pkg::ST_RESTART;
                    n_out_f      = r_f;
                    n_out_bytes  = r_count;
                end
                n_f     = '0;
                n_blk   = '0;
                n_skip  = '0;
                n_shift = '0;
                n_phase = e3hp_pkg::P_SYNC;
                n_left  = 5'd16;
                n_count = 10'd1;
                n_busy  = 1'b1;
            end else if (r_phase != e3hp_pkg::P_IDLE) begin
                if (r_count != 10'h3FF) n_count = r_count + 10'd1;
                n_busy = 1'b1;
            end
        end else if (r_busy && out_free) begin
            n_byte = {r_byte[6:0], 1'b0};
            n_bitn = r_bitn + 3'd1;
            if (r_bitn == 3'd7) n_busy = 1'b0;
            if (r_phase == e3hp_pkg::P_MIXSKIP || r_phase == e3hp_pkg::P_ADDSKIP) begin
                if (r_skip != 10'd0) n_skip = r_skip - 10'd1;
                done = (n_skip == 10'd0);
            end else begin
                v = {r_shift[14:0], r_byte[7]};
                n_shift = v;
                if (r_left != 5'd0) n_left = r_left - 5'd1;
                done = (n_left == 5'd0);
            end
            if (done) begin
                n_shift = '0;
                g.bits  = 5'd0;
                g.ph    = e3hp_pkg::P_IDLE;
                unique case (r_phase)
                    e3hp_pkg::P_SYNC:
                        g = (v == e3hp_pkg::SYNC_WORD) ?
                            e3hp_pkg::f_go(e3hp_pkg::P_STRMTYP, 5'd2) :
                            e3hp_pkg::f_go(e3hp_pkg::P_BADSYNC, 5'd0);
                    e3hp_pkg::P_STRMTYP: begin
                        n_f.stream_type = v[1:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_SUBID, 5'd3);
                    end
                    e3hp_pkg::P_SUBID: begin
                        n_f.substream_id = v[2:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_FRMSIZ, 5'd11);
                    end
                    e3hp_pkg::P_FRMSIZ: begin
                        n_f.frame_size_words = v[10:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_FSCOD, 5'd2);
                    end
                    e3hp_pkg::P_FSCOD: begin
                        n_f.rate_code = v[1:0];
                        if (v[1:0] == 2'd3) begin
                            g = e3hp_pkg::f_go(e3hp_pkg::P_FSCOD2, 5'd2);
                        end else begin
                            n_f.reduced_rate_code = 2'd3;
                            g = e3hp_pkg::f_go(e3hp_pkg::P_NUMBLKS, 5'd2);
                        end
                    end
                    e3hp_pkg::P_FSCOD2: begin
                        n_f.reduced_rate_code = v[1:0];
                        n_f.blocks_code       = 2'd3;
                        g = e3hp_pkg::f_go(e3hp_pkg::P_ACMOD, 5'd3);
                    end
                    e3hp_pkg::P_NUMBLKS: begin
                        n_f.blocks_code = v[1:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_ACMOD, 5'd3);
                    end
                    e3hp_pkg::P_ACMOD: begin
                        n_f.channel_mode = v[2:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_LFEON, 5'd1);
                    end
                    e3hp_pkg::P_LFEON: begin
                        n_f.lfe_present = v[0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_BSID, 5'd5);
                    end
                    e3hp_pkg::P_BSID: begin
                        n_f.stream_id = v[4:0];
                        g = (v[4:0] < e3hp_pkg::BSID_MIN || v[4:0] > e3hp_pkg::BSID_MAX) ?
                            e3hp_pkg::f_go(e3hp_pkg::P_BADBSID, 5'd0) :
                            e3hp_pkg::f_go(e3hp_pkg::P_DIALNORM, 5'd5);
                    end
                    e3hp_pkg::P_DIALNORM: begin
                        n_f.dialogue_level = v[4:0];
                        g = e3hp_pkg::f_go(e3hp_pkg::P_COMPRE, 5'd1);
                    end
                    e3hp_pkg::P_COMPRE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_COMPR, 5'd8)
                                 : e3hp_pkg::to_dual(r_f);
                    e3hp_pkg::P_COMPR: g = e3hp_pkg::to_dual(r_f);
                    e3hp_pkg::P_DIALNORM2: g = e3hp_pkg::f_go(e3hp_pkg::P_COMPR2E, 5'd1);
                    e3hp_pkg::P_COMPR2E:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_COMPR2, 5'd8)
                                 : e3hp_pkg::to_chanmape(r_f);
                    e3hp_pkg::P_COMPR2: g = e3hp_pkg::to_chanmape(r_f);
                    e3hp_pkg::P_CHANMAPE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_CHANMAP, 5'd16)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_MIXMDATE, 5'd1);
                    e3hp_pkg::P_CHANMAP: g = e3hp_pkg::f_go(e3hp_pkg::P_MIXMDATE, 5'd1);
                    e3hp_pkg::P_MIXMDATE:
                        g = v[0] ? e3hp_pkg::to_dmix(r_f)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_INFOMDATE, 5'd1);
                    e3hp_pkg::P_DMIX: g = e3hp_pkg::to_cmix(r_f);
                    e3hp_pkg::P_CMIX: g = e3hp_pkg::to_surmix(r_f);
                    e3hp_pkg::P_SURMIX: g = e3hp_pkg::to_lfemix(r_f);
                    e3hp_pkg::P_LFEMIXE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_LFEMIXCOD, 5'd5)
                                 : e3hp_pkg::to_pgm(r_f);
                    e3hp_pkg::P_LFEMIXCOD: g = e3hp_pkg::to_pgm(r_f);
                    e3hp_pkg::P_PGMSCLE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_PGMSCL, 5'd6)
                                 : e3hp_pkg::to_pgm2(r_f);
                    e3hp_pkg::P_PGMSCL: g = e3hp_pkg::to_pgm2(r_f);
                    e3hp_pkg::P_PGMSCL2E:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_PGMSCL2, 5'd6)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_EXTPGMSCLE, 5'd1);
                    e3hp_pkg::P_PGMSCL2: g = e3hp_pkg::f_go(e3hp_pkg::P_EXTPGMSCLE, 5'd1);
                    e3hp_pkg::P_EXTPGMSCLE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_EXTPGMSCL, 5'd6)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_MIXDEF, 5'd2);
                    e3hp_pkg::P_EXTPGMSCL: g = e3hp_pkg::f_go(e3hp_pkg::P_MIXDEF, 5'd2);
                    e3hp_pkg::P_MIXDEF: begin
                        unique case (v[1:0])
                            2'd1: g = e3hp_pkg::f_go(e3hp_pkg::P_PREMIX, 5'd5);
                            2'd2: g = e3hp_pkg::f_go(e3hp_pkg::P_MIXDATA, 5'd12);
                            2'd3: g = e3hp_pkg::f_go(e3hp_pkg::P_MIXDEFLEN, 5'd5);
                            default: g = e3hp_pkg::to_pan(r_f);
                        endcase
                    end
                    e3hp_pkg::P_PREMIX, e3hp_pkg::P_MIXDATA, e3hp_pkg::P_MIXSKIP:
                        g = e3hp_pkg::to_pan(r_f);
                    e3hp_pkg::P_MIXDEFLEN: begin
                        // skip (len + 2) bytes of mix data
                        n_skip = ({5'd0, v[4:0]} + 10'd2) << 3;
                        g = e3hp_pkg::f_go(e3hp_pkg::P_MIXSKIP, r_left);
                    end
                    e3hp_pkg::P_PANE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_PAN, 5'd14)
                                 : e3hp_pkg::to_pan2(r_f);
                    e3hp_pkg::P_PAN: g = e3hp_pkg::to_pan2(r_f);
                    e3hp_pkg::P_PAN2E:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_PAN2, 5'd14)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_FRMMIXCFGE, 5'd1);
                    e3hp_pkg::P_PAN2: g = e3hp_pkg::f_go(e3hp_pkg::P_FRMMIXCFGE, 5'd1);
                    e3hp_pkg::P_FRMMIXCFGE: begin
                        if (!v[0]) begin
                            g = e3hp_pkg::f_go(e3hp_pkg::P_INFOMDATE, 5'd1);
                        end else if (r_f.blocks_code == 2'd0) begin
                            g = e3hp_pkg::f_go(e3hp_pkg::P_BLKCFG0, 5'd5);
                        end else begin
                            n_blk = 3'd0;
                            g = e3hp_pkg::to_blkloop(r_f, 3'd0);
                        end
                    end
                    e3hp_pkg::P_BLKCFG0: g = e3hp_pkg::f_go(e3hp_pkg::P_INFOMDATE, 5'd1);
                    e3hp_pkg::P_BLKCFGE: begin
                        if (v[0]) begin
                            g = e3hp_pkg::f_go(e3hp_pkg::P_BLKCFG, 5'd5);
                        end else begin
                            n_blk = r_blk + 3'd1;
                            g = e3hp_pkg::to_blkloop(r_f, r_blk + 3'd1);
                        end
                    end
                    e3hp_pkg::P_BLKCFG: begin
                        n_blk = r_blk + 3'd1;
                        g = e3hp_pkg::to_blkloop(r_f, r_blk + 3'd1);
                    end
                    e3hp_pkg::P_INFOMDATE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_INFOA, 5'd5)
                                 : e3hp_pkg::to_convsync(r_f);
                    e3hp_pkg::P_INFOA: g = e3hp_pkg::to_dsur(r_f);
                    e3hp_pkg::P_DSUR: g = e3hp_pkg::to_dsurex(r_f);
                    e3hp_pkg::P_DSUREX: g = e3hp_pkg::f_go(e3hp_pkg::P_AUDPRODIE, 5'd1);
                    e3hp_pkg::P_AUDPRODIE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_AUDPRODI, 5'd8)
                                 : e3hp_pkg::to_audprodi2e(r_f);
                    e3hp_pkg::P_AUDPRODI: g = e3hp_pkg::to_audprodi2e(r_f);
                    e3hp_pkg::P_AUDPRODI2E:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_AUDPRODI2, 5'd8)
                                 : e3hp_pkg::to_sourcefs(r_f);
                    e3hp_pkg::P_AUDPRODI2: g = e3hp_pkg::to_sourcefs(r_f);
                    e3hp_pkg::P_SRCFS: g = e3hp_pkg::to_convsync(r_f);
                    e3hp_pkg::P_CONVSYNC: g = e3hp_pkg::to_blkid(r_f);
                    e3hp_pkg::P_BLKID:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_FRMSIZECOD, 5'd6)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_ADDBSIE, 5'd1);
                    e3hp_pkg::P_FRMSIZECOD: g = e3hp_pkg::f_go(e3hp_pkg::P_ADDBSIE, 5'd1);
                    e3hp_pkg::P_ADDBSIE:
                        g = v[0] ? e3hp_pkg::f_go(e3hp_pkg::P_ADDBSIL, 5'd6)
                                 : e3hp_pkg::f_go(e3hp_pkg::P_DONE, 5'd0);
                    e3hp_pkg::P_ADDBSIL: begin
                        // skip (len + 1) bytes of additional info
                        n_skip = ({4'd0, v[5:0]} + 10'd1) << 3;
                        g = e3hp_pkg::f_go(e3hp_pkg::P_ADDSKIP, r_left);
                    end
                    e3hp_pkg::P_ADDSKIP: g = e3hp_pkg::f_go(e3hp_pkg::P_DONE, 5'd0);
                    default: g = e3hp_pkg::f_go(e3hp_pkg::P_IDLE, 5'd0);
                endcase
                n_phase = g.ph;
                n_left  = g.bits;
                fin = (g.ph == e3hp_pkg::P_DONE) || (g.ph == e3hp_pkg::P_BADSYNC) ||
                      (g.ph == e3hp_pkg::P_BADBSID);
                if (fin) begin
                    n_out_valid  = 1'b1;
                    n_out_f      = n_f;
                    n_out_bytes  = r_count;
                    n_out_status = (g.ph == e3hp_pkg::P_DONE)    ? e3hp_pkg::ST_OK :
                                   (g.ph == e3hp_pkg::P_BADSYNC) ? e3hp_pkg::ST_BADSYNC :
                                                                   e3hp_pkg::ST_BADBSID;
                    n_phase = e3hp_pkg::P_IDLE;
                    n_busy  = 1'b0;   // drop the rest of the byte
                end
            end
        end
    end
endmodule

// ===== verif/eac3_header_field_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eac3_header_field_checker
// Watches both channels of the E-AC-3 header parser. It walks each accepted
// byte through its own bit-level header walk and queues the expected header
// records. Each delivered record is then compared field by field.
// ----------------------------------------------------------------------------
module eac3_header_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [1:0]  i_stream_type,
    input  logic [2:0]  i_substream_id,
    input  logic [10:0] i_frame_size_words,
    input  logic [1:0]  i_rate_code,
    input  logic [1:0]  i_reduced_rate_code,
    input  logic [1:0]  i_blocks_code,
    input  logic [2:0]  i_channel_mode,
    input  logic        i_lfe_present,
    input  logic [4:0]  i_stream_id,
    input  logic [4:0]  i_dialogue_level,
    input  logic [9:0]  i_header_bytes,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        e3hp_pkg::t_status status;
        e3hp_pkg::t_fields f;
        logic [9:0]        nbytes;
    } t_header_rec;

    t_header_rec expected_headers[$];

    // header walk state
    e3hp_pkg::t_phase  ph;
    int unsigned       nleft;
    logic [15:0]       acc;
    int unsigned       skip;
    logic [2:0]        blk;
    e3hp_pkg::t_fields cf;
    logic [9:0]        nbytes;

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        ph = e3hp_pkg::P_IDLE; nleft = 0; acc = '0; skip = 0; blk = '0; cf = '0;
        nbytes = '0;
    end

    assign o_pending = expected_headers.size();

    task automatic enter(input e3hp_pkg::t_phase p, input int n);
        ph    = p;
        nleft = n;
        acc   = '0;
    endtask

    // Resolve the next conditional field, falling through absent ones.
    task automatic route(input e3hp_pkg::t_phase t);
        bit done;
        int nblk;
        done = 1'b0;
        while (!done) begin
            done = 1'b1;
            case (t)
                e3hp_pkg::P_DIALNORM2:
                    if (cf.channel_mode == 0) enter(e3hp_pkg::P_DIALNORM2, 5);
                    else begin t = e3hp_pkg::P_CHANMAPE; done = 1'b0; end
                e3hp_pkg::P_CHANMAPE:
                    if (cf.stream_type == 1) enter(e3hp_pkg::P_CHANMAPE, 1);
                    else enter(e3hp_pkg::P_MIXMDATE, 1);
                e3hp_pkg::P_DMIX:
                    if (cf.channel_mode > 2) enter(e3hp_pkg::P_DMIX, 2);
                    else begin t = e3hp_pkg::P_CMIX; done = 1'b0; end
                e3hp_pkg::P_CMIX:
                    if (cf.channel_mode[0] && cf.channel_mode > 2) enter(e3hp_pkg::P_CMIX, 6);
                    else begin t = e3hp_pkg::P_SURMIX; done = 1'b0; end
                e3hp_pkg::P_SURMIX:
                    if (cf.channel_mode[2]) enter(e3hp_pkg::P_SURMIX, 6);
                    else begin t = e3hp_pkg::P_LFEMIXE; done = 1'b0; end
                e3hp_pkg::P_LFEMIXE:
                    if (cf.lfe_present) enter(e3hp_pkg::P_LFEMIXE, 1);
                    else begin t = e3hp_pkg::P_PGMSCLE; done = 1'b0; end
                e3hp_pkg::P_PGMSCLE:
                    if (cf.stream_type == 0) enter(e3hp_pkg::P_PGMSCLE, 1);
                    else enter(e3hp_pkg::P_INFOMDATE, 1);
                e3hp_pkg::P_PGMSCL2E:
                    if (cf.channel_mode == 0) enter(e3hp_pkg::P_PGMSCL2E, 1);
                    else enter(e3hp_pkg::P_EXTPGMSCLE, 1);
                e3hp_pkg::P_PANE:
                    if (cf.channel_mode < 2) enter(e3hp_pkg::P_PANE, 1);
                    else enter(e3hp_pkg::P_FRMMIXCFGE, 1);
                e3hp_pkg::P_PAN2E:
                    if (cf.channel_mode == 0) enter(e3hp_pkg::P_PAN2E, 1);
                    else enter(e3hp_pkg::P_FRMMIXCFGE, 1);
                e3hp_pkg::P_BLKCFGE: begin
                    case (cf.blocks_code)
                        2'd0: nblk = 1;
                        2'd1: nblk = 2;
                        2'd2: nblk = 3;
                        default: nblk = 6;
                    endcase
                    if (blk < nblk) enter(e3hp_pkg::P_BLKCFGE, 1);
                    else enter(e3hp_pkg::P_INFOMDATE, 1);
                end
                e3hp_pkg::P_DSUR:
                    if (cf.channel_mode == 2) enter(e3hp_pkg::P_DSUR, 4);
                    else begin t = e3hp_pkg::P_DSUREX; done = 1'b0; end
                e3hp_pkg::P_DSUREX:
                    if (cf.channel_mode >= 6) enter(e3hp_pkg::P_DSUREX, 2);
                    else enter(e3hp_pkg::P_AUDPRODIE, 1);
                e3hp_pkg::P_AUDPRODI2E:
                    if (cf.channel_mode == 0) enter(e3hp_pkg::P_AUDPRODI2E, 1);
                    else begin t = e3hp_pkg::P_SRCFS; done = 1'b0; end
                e3hp_pkg::P_SRCFS:
                    if (cf.rate_code < 3) enter(e3hp_pkg::P_SRCFS, 1);
                    else begin t = e3hp_pkg::P_CONVSYNC; done = 1'b0; end
                e3hp_pkg::P_CONVSYNC:
                    if (cf.stream_type == 0 && cf.blocks_code != 3)
                        enter(e3hp_pkg::P_CONVSYNC, 1);
                    else begin t = e3hp_pkg::P_BLKID; done = 1'b0; end
                e3hp_pkg::P_BLKID:
                    if (cf.stream_type == 2) begin
                        if (cf.blocks_code == 3) enter(e3hp_pkg::P_FRMSIZECOD, 6);
                        else enter(e3hp_pkg::P_BLKID, 1);
                    end else enter(e3hp_pkg::P_ADDBSIE, 1);
                default: enter(t, 1);
            endcase
        end
    endtask

    task automatic field_done(input logic [15:0] v);
        bit f;
        f = (v != 0);
        case (ph)
            e3hp_pkg::P_SYNC:
                if (v != e3hp_pkg::SYNC_WORD) ph = e3hp_pkg::P_BADSYNC;
                else enter(e3hp_pkg::P_STRMTYP, 2);
            e3hp_pkg::P_STRMTYP: begin
                cf.stream_type = v[1:0]; enter(e3hp_pkg::P_SUBID, 3);
            end
            e3hp_pkg::P_SUBID: begin
                cf.substream_id = v[2:0]; enter(e3hp_pkg::P_FRMSIZ, 11);
            end
            e3hp_pkg::P_FRMSIZ: begin
                cf.frame_size_words = v[10:0]; enter(e3hp_pkg::P_FSCOD, 2);
            end
            e3hp_pkg::P_FSCOD: begin
                cf.rate_code = v[1:0];
                if (v[1:0] == 2'd3) enter(e3hp_pkg::P_FSCOD2, 2);
                else begin cf.reduced_rate_code = 2'd3; enter(e3hp_pkg::P_NUMBLKS, 2); end
            end
            e3hp_pkg::P_FSCOD2: begin
                cf.reduced_rate_code = v[1:0];
                cf.blocks_code = 2'd3;
                enter(e3hp_pkg::P_ACMOD, 3);
            end
            e3hp_pkg::P_NUMBLKS: begin
                cf.blocks_code = v[1:0]; enter(e3hp_pkg::P_ACMOD, 3);
            end
            e3hp_pkg::P_ACMOD: begin
                cf.channel_mode = v[2:0]; enter(e3hp_pkg::P_LFEON, 1);
            end
            e3hp_pkg::P_LFEON: begin
                cf.lfe_present = v[0]; enter(e3hp_pkg::P_BSID, 5);
            end
            e3hp_pkg::P_BSID: begin
                cf.stream_id = v[4:0];
                if (v[4:0] < e3hp_pkg::BSID_MIN || v[4:0] > e3hp_pkg::BSID_MAX)
                    ph = e3hp_pkg::P_BADBSID;
                else enter(e3hp_pkg::P_DIALNORM, 5);
            end
            e3hp_pkg::P_DIALNORM: begin
                cf.dialogue_level = v[4:0]; enter(e3hp_pkg::P_COMPRE, 1);
            end
            e3hp_pkg::P_COMPRE:
                if (f) enter(e3hp_pkg::P_COMPR, 8); else route(e3hp_pkg::P_DIALNORM2);
            e3hp_pkg::P_COMPR:     route(e3hp_pkg::P_DIALNORM2);
            e3hp_pkg::P_DIALNORM2: enter(e3hp_pkg::P_COMPR2E, 1);
            e3hp_pkg::P_COMPR2E:
                if (f) enter(e3hp_pkg::P_COMPR2, 8); else route(e3hp_pkg::P_CHANMAPE);
            e3hp_pkg::P_COMPR2:    route(e3hp_pkg::P_CHANMAPE);
            e3hp_pkg::P_CHANMAPE:
                if (f) enter(e3hp_pkg::P_CHANMAP, 16); else enter(e3hp_pkg::P_MIXMDATE, 1);
            e3hp_pkg::P_CHANMAP:   enter(e3hp_pkg::P_MIXMDATE, 1);
            e3hp_pkg::P_MIXMDATE:
                if (f) route(e3hp_pkg::P_DMIX); else enter(e3hp_pkg::P_INFOMDATE, 1);
            e3hp_pkg::P_DMIX:      route(e3hp_pkg::P_CMIX);
            e3hp_pkg::P_CMIX:      route(e3hp_pkg::P_SURMIX);
            e3hp_pkg::P_SURMIX:    route(e3hp_pkg::P_LFEMIXE);
            e3hp_pkg::P_LFEMIXE:
                if (f) enter(e3hp_pkg::P_LFEMIXCOD, 5); else route(e3hp_pkg::P_PGMSCLE);
            e3hp_pkg::P_LFEMIXCOD: route(e3hp_pkg::P_PGMSCLE);
            e3hp_pkg::P_PGMSCLE:
                if (f) enter(e3hp_pkg::P_PGMSCL, 6); else route(e3hp_pkg::P_PGMSCL2E);
            e3hp_pkg::P_PGMSCL:    route(e3hp_pkg::P_PGMSCL2E);
            e3hp_pkg::P_PGMSCL2E:
                if (f) enter(e3hp_pkg::P_PGMSCL2, 6); else enter(e3hp_pkg::P_EXTPGMSCLE, 1);
            e3hp_pkg::P_PGMSCL2:   enter(e3hp_pkg::P_EXTPGMSCLE, 1);
            e3hp_pkg::P_EXTPGMSCLE:
                if (f) enter(e3hp_pkg::P_EXTPGMSCL, 6); else enter(e3hp_pkg::P_MIXDEF, 2);
            e3hp_pkg::P_EXTPGMSCL: enter(e3hp_pkg::P_MIXDEF, 2);
            e3hp_pkg::P_MIXDEF:
                case (v[1:0])
                    2'd1:    enter(e3hp_pkg::P_PREMIX, 5);
                    2'd2:    enter(e3hp_pkg::P_MIXDATA, 12);
                    2'd3:    enter(e3hp_pkg::P_MIXDEFLEN, 5);
                    default: route(e3hp_pkg::P_PANE);
                endcase
            e3hp_pkg::P_PREMIX, e3hp_pkg::P_MIXDATA: route(e3hp_pkg::P_PANE);
            e3hp_pkg::P_MIXDEFLEN: begin
                skip = (v[4:0] + 2) * 8; ph = e3hp_pkg::P_MIXSKIP;
            end
            e3hp_pkg::P_MIXSKIP:   route(e3hp_pkg::P_PANE);
            e3hp_pkg::P_PANE:
                if (f) enter(e3hp_pkg::P_PAN, 14); else route(e3hp_pkg::P_PAN2E);
            e3hp_pkg::P_PAN:       route(e3hp_pkg::P_PAN2E);
            e3hp_pkg::P_PAN2E:
                if (f) enter(e3hp_pkg::P_PAN2, 14); else enter(e3hp_pkg::P_FRMMIXCFGE, 1);
            e3hp_pkg::P_PAN2:      enter(e3hp_pkg::P_FRMMIXCFGE, 1);
            e3hp_pkg::P_FRMMIXCFGE:
                if (!f) enter(e3hp_pkg::P_INFOMDATE, 1);
                else if (cf.blocks_code == 0) enter(e3hp_pkg::P_BLKCFG0, 5);
                else begin blk = '0; route(e3hp_pkg::P_BLKCFGE); end
            e3hp_pkg::P_BLKCFG0:   enter(e3hp_pkg::P_INFOMDATE, 1);
            e3hp_pkg::P_BLKCFGE:
                if (f) enter(e3hp_pkg::P_BLKCFG, 5);
                else begin blk = blk + 1'b1; route(e3hp_pkg::P_BLKCFGE); end
            e3hp_pkg::P_BLKCFG: begin
                blk = blk + 1'b1; route(e3hp_pkg::P_BLKCFGE);
            end
            e3hp_pkg::P_INFOMDATE:
                if (f) enter(e3hp_pkg::P_INFOA, 5); else route(e3hp_pkg::P_CONVSYNC);
            e3hp_pkg::P_INFOA:     route(e3hp_pkg::P_DSUR);
            e3hp_pkg::P_DSUR:      route(e3hp_pkg::P_DSUREX);
            e3hp_pkg::P_DSUREX:    enter(e3hp_pkg::P_AUDPRODIE, 1);
            e3hp_pkg::P_AUDPRODIE:
                if (f) enter(e3hp_pkg::P_AUDPRODI, 8); else route(e3hp_pkg::P_AUDPRODI2E);
            e3hp_pkg::P_AUDPRODI:  route(e3hp_pkg::P_AUDPRODI2E);
            e3hp_pkg::P_AUDPRODI2E:
                if (f) enter(e3hp_pkg::P_AUDPRODI2, 8); else route(e3hp_pkg::P_SRCFS);
            e3hp_pkg::P_AUDPRODI2: route(e3hp_pkg::P_SRCFS);
            e3hp_pkg::P_SRCFS:     route(e3hp_pkg::P_CONVSYNC);
            e3hp_pkg::P_CONVSYNC:  route(e3hp_pkg::P_BLKID);
            e3hp_pkg::P_BLKID:
                if (f) enter(e3hp_pkg::P_FRMSIZECOD, 6); else enter(e3hp_pkg::P_ADDBSIE, 1);
            e3hp_pkg::P_FRMSIZECOD: enter(e3hp_pkg::P_ADDBSIE, 1);
            e3hp_pkg::P_ADDBSIE:
                if (f) enter(e3hp_pkg::P_ADDBSIL, 6); else ph = e3hp_pkg::P_DONE;
            e3hp_pkg::P_ADDBSIL: begin
                skip = (v[5:0] + 1) * 8; ph = e3hp_pkg::P_ADDSKIP;
            end
            e3hp_pkg::P_ADDSKIP:   ph = e3hp_pkg::P_DONE;
            default:               ph = e3hp_pkg::P_IDLE;
        endcase
    endtask

    function automatic bit header_over();
        return ph == e3hp_pkg::P_DONE || ph == e3hp_pkg::P_BADSYNC ||
               ph == e3hp_pkg::P_BADBSID;
    endfunction

    task automatic push_header(input e3hp_pkg::t_status st);
        t_header_rec r;
        r.status = st;
        r.f      = cf;
        r.nbytes = nbytes;
        expected_headers.push_back(r);
    endtask

    task automatic walk_byte(input logic [7:0] d, input logic s);
        if (s) begin
            if (ph != e3hp_pkg::P_IDLE) push_header(e3hp_pkg::ST_RESTART);
            cf = '0; nbytes = '0; skip = 0; blk = '0;
            enter(e3hp_pkg::P_SYNC, 16);
        end
        if (ph == e3hp_pkg::P_IDLE) return;
        if (nbytes != 10'h3FF) nbytes = nbytes + 1'b1;
        for (int b = 7; b >= 0; b--) begin
            if (header_over()) break;
            if (ph == e3hp_pkg::P_MIXSKIP || ph == e3hp_pkg::P_ADDSKIP) begin
                if (skip > 0) skip--;
                if (skip == 0) field_done('0);
            end else begin
                acc = {acc[14:0], d[b]};
                if (nleft > 0) nleft--;
                if (nleft == 0) field_done(acc);
            end
        end
        if (header_over()) begin
            push_header(ph == e3hp_pkg::P_DONE ? e3hp_pkg::ST_OK :
                        (ph == e3hp_pkg::P_BADSYNC ? e3hp_pkg::ST_BADSYNC :
                                                     e3hp_pkg::ST_BADBSID));
            ph = e3hp_pkg::P_IDLE;
        end
    endtask

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            o_fail_count++;
        end
    endtask

    // Sample mid-cycle: everything is settled, and the beat moves at the next edge.
    always @(negedge i_clk) begin
        t_header_rec e;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) walk_byte(i_data_byte, i_frame_start);
            if (i_out_valid && !i_out_stall) begin
                if (expected_headers.size() == 0) begin
                    $error("header result with none expected");
                    o_fail_count++;
                end else begin
                    e = expected_headers.pop_front();
                    o_checked++;
                    check_field("status", e.status, i_status);
                    check_field("stream_type", e.f.stream_type, i_stream_type);
                    check_field("substream_id", e.f.substream_id, i_substream_id);
                    check_field("frame_size_words", e.f.frame_size_words, i_frame_size_words);
                    check_field("rate_code", e.f.rate_code, i_rate_code);
                    check_field("reduced_rate_code", e.f.reduced_rate_code,
                                i_reduced_rate_code);
                    check_field("blocks_code", e.f.blocks_code, i_blocks_code);
                    check_field("channel_mode", e.f.channel_mode, i_channel_mode);
                    check_field("lfe_present", e.f.lfe_present, i_lfe_present);
                    check_field("stream_id", e.f.stream_id, i_stream_id);
                    check_field("dialogue_level", e.f.dialogue_level, i_dialogue_level);
                    check_field("header_bytes", e.nbytes, i_header_bytes);
                end
            end
        end
    end

endmodule

// ===== verif/eac3_header_field_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eac3_header_field_parser_test
// Feeds E-AC-3 frames (directed corner frames, then random well-formed frames
// mixed with broken syncs, bad bsid values and noise bytes) through the
// parser under four flow-control phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module eac3_header_field_parser_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_start = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_out_valid, o_lfe_present;
    logic [1:0]  o_status, o_stream_type, o_rate_code, o_reduced_rate_code, o_blocks_code;
    logic [2:0]  o_substream_id, o_channel_mode;
    logic [10:0] o_frame_size_words;
    logic [4:0]  o_stream_id, o_dialogue_level;
    logic [9:0]  o_header_bytes;

    int fail_count, pending, checked;
    int cycles = 0;
    int beats = 0;
    int frames = 0;
    // percentages of idle sender cycles and stalled receiver cycles
    int idle_pct = 0;
    int stall_pct = 0;
    // hold-off request: bump hold_seq to start one long receiver stall
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit hdr_bits[$];

    eac3_header_field_parser uut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_data_byte, .i_frame_start,
        .o_out_valid, .i_out_stall, .o_status, .o_stream_type, .o_substream_id,
        .o_frame_size_words, .o_rate_code, .o_reduced_rate_code, .o_blocks_code,
        .o_channel_mode, .o_lfe_present, .o_stream_id, .o_dialogue_level, .o_header_bytes
    );

    eac3_header_field_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_data_byte,
        .i_frame_start, .i_out_valid(o_out_valid), .i_out_stall,
        .i_status(o_status), .i_stream_type(o_stream_type),
        .i_substream_id(o_substream_id), .i_frame_size_words(o_frame_size_words),
        .i_rate_code(o_rate_code), .i_reduced_rate_code(o_reduced_rate_code),
        .i_blocks_code(o_blocks_code), .i_channel_mode(o_channel_mode),
        .i_lfe_present(o_lfe_present), .i_stream_id(o_stream_id),
        .i_dialogue_level(o_dialogue_level), .i_header_bytes(o_header_bytes),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off while the sender keeps pushing.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_seq) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one beat; return once it has been taken. Valid stays up between
    // back-to-back beats and drops only for an idle gap.
    task automatic send_beat(input logic [7:0] d, input logic s);
        logic st;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= d;
        i_frame_start <= s;
        do begin
            @(negedge i_clk);
            st = o_in_stall;
            @(posedge i_clk);
        end while (st);
        beats++;
    endtask

    task automatic put_bits(input int unsigned v, input int n);
        for (int i = n - 1; i >= 0; i--) hdr_bits.push_back((v >> i) & 1);
    endtask

    // Build one frame: syncword, fixed leading fields, then a tail whose bits
    // steer every optional branch. Tail fill: 0 zeros, 1 ones, 2 random.
    task automatic send_frame(input int sync, input int strm, input int subid,
                              input int frmsiz, input int fscod, input int nblk,
                              input int acmod, input int lfe, input int bsid,
                              input int tail_len, input int fill);
        logic [7:0] b;
        hdr_bits.delete();
        put_bits(sync, 16);
        put_bits(strm, 2);
        put_bits(subid, 3);
        put_bits(frmsiz, 11);
        put_bits(fscod, 2);
        put_bits(nblk, 2);
        put_bits(acmod, 3);
        put_bits(lfe, 1);
        put_bits(bsid, 5);
        while (hdr_bits.size() < 48 + 8 * tail_len)
            hdr_bits.push_back(fill == 2 ? $urandom_range(1) : fill);
        for (int k = 0; k < hdr_bits.size() / 8; k++) begin
            for (int i = 0; i < 8; i++) b[7 - i] = hdr_bits[8 * k + i];
            send_beat(b, k == 0);
        end
        frames++;
    endtask

    task automatic send_random_frame();
        int bsid, tail, pick;
        pick = $urandom_range(99);
        bsid = ($urandom_range(9) < 8) ? $urandom_range(16, 11) : $urandom_range(31);
        tail = ($urandom_range(19) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 2);
        if (pick < 8) begin
            // broken syncword, then garbage
            send_frame($urandom_range(16'hFFFF), $urandom_range(3), $urandom_range(7),
                       $urandom_range(2047), $urandom_range(3), $urandom_range(3),
                       $urandom_range(7), $urandom_range(1), bsid, 0, 2);
        end else if (pick < 18) begin
            // noise: mostly ignored idle bytes, an occasional stray frame start
            repeat ($urandom_range(6, 1))
                send_beat($urandom_range(255), $urandom_range(7) == 0);
        end else begin
            send_frame(e3hp_pkg::SYNC_WORD, $urandom_range(3), $urandom_range(7),
                       $urandom_range(2047), $urandom_range(3), $urandom_range(3),
                       $urandom_range(7), $urandom_range(1), bsid, tail, 2);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle bytes, bad syncword, field extremes, every branch
        // driven all-ones and all-zeros, bsid limits, and an early restart.
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h0B, 1'b1);
        send_beat(8'h78, 1'b0);
        send_frame(e3hp_pkg::SYNC_WORD, 0, 0, 0, 0, 0, 1, 0, 16, 4, 0);
        send_frame(e3hp_pkg::SYNC_WORD, 3, 7, 2047, 3, 3, 7, 1, 11, 130, 1);
        send_frame(e3hp_pkg::SYNC_WORD, 0, 5, 1234, 0, 0, 0, 1, 12, 130, 1);
        send_frame(e3hp_pkg::SYNC_WORD, 2, 1, 77, 1, 1, 2, 1, 16, 130, 1);
        send_frame(e3hp_pkg::SYNC_WORD, 1, 2, 500, 2, 2, 6, 0, 15, 40, 2);
        send_frame(e3hp_pkg::SYNC_WORD, 0, 0, 0, 0, 0, 0, 0, 10, 1, 0);
        send_frame(e3hp_pkg::SYNC_WORD, 0, 0, 0, 0, 0, 0, 0, 17, 1, 0);
        send_frame(e3hp_pkg::SYNC_WORD, 3, 7, 2047, 3, 3, 7, 1, 31, 1, 1);
        send_frame(e3hp_pkg::SYNC_WORD, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        // restart in the middle of an extended program scale field
        send_frame(e3hp_pkg::SYNC_WORD, 0, 3, 9, 1, 3, 1, 0, 13, 3, 1);
        send_frame(e3hp_pkg::SYNC_WORD, 1, 0, 3, 0, 3, 3, 1, 14, 20, 2);

        // Random phases: no idling, sender idle, receiver stalling, both light.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 81 : (ph == 3) ? 7 : 0;
            stall_pct = (ph == 2) ? 81 : (ph == 3) ? 7 : 0;
            for (int n = beats + 100; beats < n; ) begin
                if (ph == 0 && hold_seq == 0 && n - beats <= 60) hold_seq++;
                send_random_frame();
            end
        end

        i_in_valid    <= 1'b0;
        i_frame_start <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("ran %0d byte beats in %0d frames under four flow-control phases",
                 beats, frames);
        $display("checked %0d header results, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
